// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while reset is released.
`define ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ----- hw/rtl/rtpext_pkg.sv -----
package rtpext_pkg;

  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgAddrW = 4;

  // Register byte addresses.
  localparam logic [CfgAddrW-1:0] REG_VIDEO_MAP = 4'h0;
  localparam logic [CfgAddrW-1:0] REG_AUDIO_MAP = 4'h8;

  localparam logic [15:0] PROFILE_ONE_BYTE = 16'hBEDE;
  localparam logic [7:0]  LEN_MASK         = 8'h0F;

  // Media codes.
  localparam logic [1:0] MEDIA_VIDEO = 2'd0;
  localparam logic [1:0] MEDIA_AUDIO = 2'd1;

  // Element type codes held in the id maps.
  localparam logic [2:0] ET_NONE   = 3'd0;
  localparam logic [2:0] ET_ORIENT = 3'd2;
  localparam logic [2:0] ET_MID    = 3'd3;
  localparam logic [2:0] ET_RID    = 3'd4;

  // Result kinds.
  localparam logic [1:0] KIND_MID    = 2'd0;
  localparam logic [1:0] KIND_RID    = 2'd1;
  localparam logic [1:0] KIND_ORIENT = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_HEADER  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        block_start;
    logic [1:0]  media;
    logic        has_extension;
    logic [15:0] profile_id;
    logic [15:0] ext_words;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [3:0] byte_index;
    logic       last;
  } result_t;

endpackage

// ----- hw/rtl/rtpext_cfg_regs.sv -----
module rtpext_cfg_regs #(
  parameter int unsigned MAP_ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rtpext_pkg::CfgAddrW-1:0]   paddr,
  input  logic [rtpext_pkg::CfgDataW-1:0]   pwdata,
  output logic [rtpext_pkg::CfgDataW-1:0]   prdata,
  output logic                              pready,
  output logic [3*MAP_ENTRIES-1:0]          video_map,
  output logic [3*MAP_ENTRIES-1:0]          audio_map
);
  import rtpext_pkg::*;

  localparam int unsigned MapW = 3 * MAP_ENTRIES;

  logic [MapW-1:0] video_map_r;
  logic [MapW-1:0] audio_map_r;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      video_map_r <= '0;
      audio_map_r <= '0;
    end else if (wr_en) begin
      unique case (paddr)
        REG_VIDEO_MAP: video_map_r <= pwdata[MapW-1:0];
        REG_AUDIO_MAP: audio_map_r <= pwdata[MapW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      REG_VIDEO_MAP: prdata = {{(CfgDataW-MapW){1'b0}}, video_map_r};
      REG_AUDIO_MAP: prdata = {{(CfgDataW-MapW){1'b0}}, audio_map_r};
      default:       prdata = '0;
    endcase
  end

  assign video_map = video_map_r;
  assign audio_map = audio_map_r;

endmodule

// ----- hw/rtl/rtpext_parse_core.sv -----
module rtpext_parse_core #(
  parameter int unsigned MAP_ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  rtpext_pkg::item_t          item,
  input  logic [3*MAP_ENTRIES-1:0]   video_map,
  input  logic [3*MAP_ENTRIES-1:0]   audio_map,
  output logic                       res_valid,
  output rtpext_pkg::result_t        res
);
  import rtpext_pkg::*;

  localparam int unsigned IdW = $clog2(MAP_ENTRIES);

  phase_t      phase_r, phase_nxt;
  logic [17:0] pos_r, pos_nxt;
  logic [17:0] blk_r, blk_nxt;
  logic [4:0]  left_r, left_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [2:0]  etype_r, etype_nxt;
  logic        audio_r, audio_nxt;
  logic [1:0]  rot_r, rot_nxt;

  logic [2:0]  map_types [MAP_ENTRIES];
  logic [3:0]  elem_id;
  logic [2:0]  looked_up;
  logic        is_last;
  logic        sel_audio;

  // A block start picks the map by its own media code; lookups only matter
  // when that block is parsed, which needs media 0 or 1.
  assign sel_audio = item.block_start ? item.media[0] : audio_r;

  // Split the selected map into one 3-bit code per id.
  for (genvar g = 0; g < MAP_ENTRIES; g++) begin : g_map
    assign map_types[g] = sel_audio ? audio_map[3*g +: 3] : video_map[3*g +: 3];
  end

  assign elem_id   = item.data_byte[7:4];
  assign looked_up = ({28'd0, elem_id} >= MAP_ENTRIES) ? ET_NONE : map_types[elem_id[IdW-1:0]];

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    blk_nxt   = blk_r;
    left_nxt  = left_r;
    idx_nxt   = idx_r;
    etype_nxt = etype_r;
    audio_nxt = audio_r;
    rot_nxt   = rot_r;
    res_valid = 1'b0;
    res       = '0;
    is_last   = 1'b0;

    if (item.block_start) begin
      pos_nxt   = '0;
      left_nxt  = '0;
      idx_nxt   = '0;
      etype_nxt = ET_NONE;
      blk_nxt   = {item.ext_words, 2'b00};
      if ((item.media == MEDIA_VIDEO || item.media == MEDIA_AUDIO) && item.has_extension &&
          item.profile_id == PROFILE_ONE_BYTE && item.ext_words != 16'd0) begin
        audio_nxt = item.media[0];
        phase_nxt = PH_HEADER;
      end else begin
        phase_nxt = PH_IDLE;
      end
    end

    if (phase_nxt != PH_IDLE && pos_nxt >= blk_nxt) begin
      phase_nxt = PH_IDLE;
    end

    unique case (phase_nxt)
      PH_IDLE: ;
      PH_HEADER: begin
        // A header needs at least one byte behind it inside the block.
        if ({1'b0, pos_nxt} + 19'd1 >= {1'b0, blk_nxt}) begin
          phase_nxt = PH_IDLE;
        end else begin
          if (elem_id != 4'd0) begin
            etype_nxt = looked_up;
            left_nxt  = 5'(item.data_byte & LEN_MASK) + 5'd1;
            idx_nxt   = '0;
            phase_nxt = PH_PAYLOAD;
          end
          pos_nxt = pos_nxt + 18'd1;
        end
      end
      PH_PAYLOAD: begin
        left_nxt = left_nxt - 5'd1;
        is_last  = (left_nxt == 5'd0);
        if (etype_nxt == ET_MID || etype_nxt == ET_RID) begin
          res_valid      = 1'b1;
          res.kind       = (etype_nxt == ET_MID) ? KIND_MID : KIND_RID;
          res.value      = item.data_byte;
          res.byte_index = idx_nxt;
          res.last       = is_last;
        end else if (etype_nxt == ET_ORIENT && idx_nxt == 4'd0) begin
          rot_nxt        = item.data_byte[1:0];
          res_valid      = 1'b1;
          res.kind       = KIND_ORIENT;
          res.value      = {6'd0, item.data_byte[1:0]};
          res.byte_index = 4'd0;
          res.last       = 1'b1;
        end
        idx_nxt = idx_nxt + 4'd1;
        if (is_last) begin
          phase_nxt = PH_HEADER;
        end
        pos_nxt = pos_nxt + 18'd1;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= '0;
      blk_r   <= '0;
      left_r  <= '0;
      idx_r   <= '0;
      etype_r <= ET_NONE;
      audio_r <= 1'b0;
      rot_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      blk_r   <= blk_nxt;
      left_r  <= left_nxt;
      idx_r   <= idx_nxt;
      etype_r <= etype_nxt;
      audio_r <= audio_nxt;
      rot_r   <= rot_nxt;
    end
  end

endmodule

// ----- hw/rtl/rtp_one_byte_ext_parser_unit.sv -----
// Path: an accepted item is registered in the input register and parsed
// combinationally; its result is registered onto the out_ ports as it advances.
// Throughput: one item per cycle while no result is stalled; one item is held in
// the input register while a stalled result waits in the output register.
// Reset: synchronous, active low; clears parse state, maps and both valid flags.
module rtp_one_byte_ext_parser_unit #(
  parameter int unsigned MAP_ENTRIES = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_data_byte,
  input  logic                             in_block_start,
  input  logic [1:0]                       in_media,
  input  logic                             in_has_extension,
  input  logic [15:0]                      in_profile_id,
  input  logic [15:0]                      in_ext_words,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_kind,
  output logic [7:0]                       out_value,
  output logic [3:0]                       out_byte_index,
  output logic                             out_last,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [rtpext_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  logic [rtpext_pkg::CfgDataW-1:0]  cfg_pwdata,
  output logic [rtpext_pkg::CfgDataW-1:0]  cfg_prdata,
  output logic                             cfg_pready
);
  import rtpext_pkg::*;

  logic [3*MAP_ENTRIES-1:0] video_map;
  logic [3*MAP_ENTRIES-1:0] audio_map;

  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    in_take;
  logic    advance;
  logic    res_valid;
  result_t res;
  logic    out_valid_r;
  result_t out_r;

  rtpext_cfg_regs #(.MAP_ENTRIES(MAP_ENTRIES)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (cfg_psel),
    .penable   (cfg_penable),
    .pwrite    (cfg_pwrite),
    .paddr     (cfg_paddr),
    .pwdata    (cfg_pwdata),
    .prdata    (cfg_prdata),
    .pready    (cfg_pready),
    .video_map (video_map),
    .audio_map (audio_map)
  );

  // The held item moves on whenever the output register is free or draining.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.data_byte     <= in_data_byte;
      s1_item_r.block_start   <= in_block_start;
      s1_item_r.media         <= in_media;
      s1_item_r.has_extension <= in_has_extension;
      s1_item_r.profile_id    <= in_profile_id;
      s1_item_r.ext_words     <= in_ext_words;
    end
  end

  rtpext_parse_core #(.MAP_ENTRIES(MAP_ENTRIES)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .item      (s1_item_r),
    .video_map (video_map),
    .audio_map (audio_map),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_r.kind;
  assign out_value      = out_r.value;
  assign out_byte_index = out_r.byte_index;
  assign out_last       = out_r.last;

endmodule

// ----- hw/rtl/rtpext_checker.sv -----
`include "assert_macros.svh"

module rtpext_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic [7:0] out_value,
  input logic [3:0] out_byte_index,
  input logic       out_last
);
  import rtpext_pkg::*;

  // Both sides come up empty in the cycle after reset is seen.
  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid && !in_stall, "not empty after reset")

  // The input side only backs up when a result is held by the receiver.
  `ASSERT_RUN(a_stall_cause, in_stall |-> out_valid && out_stall, "input stall without output stall")

  // An orientation update is a single final item carrying a two-bit code.
  `ASSERT_RUN(a_orient_form,
    out_valid && out_kind == KIND_ORIENT |->
      out_last && out_byte_index == 4'd0 && out_value[7:2] == 6'd0,
    "malformed orientation result")

  `ASSERT_RUN(a_out_hold,
    out_valid && out_stall |=>
      out_valid && $stable(out_kind) && $stable(out_value) &&
      $stable(out_byte_index) && $stable(out_last),
    "stalled result changed")

endmodule

bind rtp_one_byte_ext_parser_unit rtpext_checker u_rtpext_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_kind       (out_kind),
  .out_value      (out_value),
  .out_byte_index (out_byte_index),
  .out_last       (out_last)
);
